// File: hdl/sobm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobm_pkg
// Shared types, constants and the gradient function of the Sobel edge block.
// ----------------------------------------------------------------------------
package sobm_pkg;

    localparam int CH_BITS   = 8;
    localparam int NUM_CH    = 3;
    localparam int PIX_BITS  = NUM_CH * CH_BITS;
    localparam int SQ_BITS   = 2 * (CH_BITS + 3) - 1;
    localparam int BIT_IDX_W = $clog2(CH_BITS);
    localparam int LW_BITS   = 12;
    localparam int FH_BITS   = 13;
    localparam int CFG_BITS  = 13;
    localparam int IDX_BITS  = 1;

    localparam logic [CH_BITS-1:0]  CH_MAX       = {CH_BITS{1'b1}};
    localparam logic [SQ_BITS-1:0]  SAT_LIMIT    = SQ_BITS'(255 * 256);
    localparam logic [FH_BITS-1:0]  HEIGHT_LIMIT = FH_BITS'(4096);
    localparam logic [LW_BITS-1:0]  LW_RESET     = LW_BITS'(640);
    localparam logic [FH_BITS-1:0]  FH_RESET     = FH_BITS'(480);

    localparam logic [IDX_BITS-1:0] REG_LINE_WIDTH   = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = IDX_BITS'(1);

    typedef logic [8:0][CH_BITS-1:0] chwin_t;

    typedef struct packed {
        logic accept;
        logic calc;
        logic root_step;
        logic load_out;
    } sobm_cmd_t;

    typedef struct packed {
        logic emit;
        logic root_last;
        logic out_free;
        logic at_origin;
    } sobm_status_t;

    function automatic logic [SQ_BITS-1:0] grad_sq(input chwin_t p);
        logic [11:0]        xp, xn, yp, yn;
        logic signed [11:0] gx, gy;
        logic signed [23:0] sx, sy;
        xp = 12'(p[2]) + (12'(p[5]) << 1) + 12'(p[8]);
        xn = 12'(p[0]) + (12'(p[3]) << 1) + 12'(p[6]);
        yp = 12'(p[6]) + (12'(p[7]) << 1) + 12'(p[8]);
        yn = 12'(p[0]) + (12'(p[1]) << 1) + 12'(p[2]);
        gx = $signed(xp - xn);
        gy = $signed(yp - yn);
        sx = gx * gx;
        sy = gy * gy;
        return SQ_BITS'(sx + sy);
    endfunction

endpackage
`default_nettype wire

// File: hdl/sobm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobm_ctrl
// Sequencer that steps one item through window update, root and output.
// ----------------------------------------------------------------------------
module sobm_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  sobm_pkg::sobm_status_t     status,
    output sobm_pkg::sobm_cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = status.emit ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (status.root_last) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/sobm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobm_dp
// Line stores, 3x3 window, raster counters, gradient squares and the
// bit-per-cycle square root with rounding and saturation.
// ----------------------------------------------------------------------------
module sobm_dp #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [sobm_pkg::IDX_BITS-1:0]     cfg_index,
    input  wire logic [sobm_pkg::CFG_BITS-1:0]     cfg_wdata,
    input  wire logic [sobm_pkg::CH_BITS-1:0]      s_red_in,
    input  wire logic [sobm_pkg::CH_BITS-1:0]      s_green_in,
    input  wire logic [sobm_pkg::CH_BITS-1:0]      s_blue_in,
    input  wire logic                              s_drain,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [sobm_pkg::CH_BITS-1:0]           m_red_edge,
    output logic [sobm_pkg::CH_BITS-1:0]           m_green_edge,
    output logic [sobm_pkg::CH_BITS-1:0]           m_blue_edge,
    output logic                                   m_frame_end,
    input  sobm_pkg::sobm_cmd_t                    cmd,
    output sobm_pkg::sobm_status_t                 status
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int CB = sobm_pkg::CH_BITS;
    localparam int PB = sobm_pkg::PIX_BITS;
    localparam int FB = sobm_pkg::FH_BITS;
    localparam int SB = sobm_pkg::SQ_BITS;
    localparam int NC = sobm_pkg::NUM_CH;

    logic [sobm_pkg::LW_BITS-1:0] line_width_reg;
    logic [FB-1:0]                frame_height_reg;
    logic [CW-1:0]                col_reg, col_next;
    logic [FB-1:0]                row_reg, row_next;
    logic [PB-1:0]                win_reg [9];
    logic [PB-1:0]                win_next [9];
    logic [PB-1:0]                out_win [9];
    logic [PB-1:0]                upper_mem [MAX_WIDTH];
    logic [PB-1:0]                middle_mem [MAX_WIDTH];
    logic [PB-1:0]                up_q_reg, mid_q_reg, pix_reg;
    logic                         drain_reg;
    logic [SB-1:0]                sq_reg [NC];
    logic [CB-1:0]                root_reg [NC];
    logic [sobm_pkg::BIT_IDX_W-1:0] bit_reg;
    logic                         last_reg;
    logic                         m_valid_reg;
    logic [CB-1:0]                edge_reg [NC];
    logic                         frame_end_reg;

    logic [WW-1:0] eff_w;
    logic [FB-1:0] eff_h;
    logic [CW-1:0] col;
    logic          col_last;
    logic [FB:0]   row_x, h_x;
    logic [PB-1:0] px, up, mid;
    logic          emit, last, restart;

    always_comb begin
        if (line_width_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(line_width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(line_width_reg);
        end
        if (frame_height_reg == '0) begin
            eff_h = FB'(1);
        end else if (frame_height_reg > sobm_pkg::HEIGHT_LIMIT) begin
            eff_h = sobm_pkg::HEIGHT_LIMIT;
        end else begin
            eff_h = frame_height_reg;
        end
    end

    assign col      = (WW'(col_reg) >= eff_w) ? '0 : col_reg;
    assign col_last = (WW'(col) + WW'(1)) >= eff_w;
    assign row_x    = {1'b0, row_reg};
    assign h_x      = {1'b0, eff_h};

    assign px  = (!drain_reg && (row_reg < eff_h)) ? pix_reg : '0;
    assign up  = (row_reg >= FB'(2)) ? up_q_reg : '0;
    assign mid = (row_reg >= FB'(1)) ? mid_q_reg : '0;

    // The frame's last result always falls on an item at column zero.
    always_comb begin
        if (col == '0) begin
            emit = (row_x >= (FB+1)'(2)) && (row_x <= h_x + (FB+1)'(1));
            last = (row_x == h_x + (FB+1)'(1));
        end else begin
            emit = (row_x >= (FB+1)'(1)) && (row_x <= h_x);
            last = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            out_win[3*k]     = win_reg[3*k+1];
            out_win[3*k+1]   = win_reg[3*k+2];
            win_next[3*k]    = '0;
            win_next[3*k+1]  = '0;
        end
        if (col == '0) begin
            out_win[2] = '0;
            out_win[5] = '0;
            out_win[8] = '0;
        end else begin
            out_win[2] = up;
            out_win[5] = mid;
            out_win[8] = px;
            for (int k = 0; k < 3; k++) begin
                win_next[3*k]   = out_win[3*k];
                win_next[3*k+1] = out_win[3*k+1];
            end
        end
        win_next[2] = up;
        win_next[5] = mid;
        win_next[8] = px;
    end

    always_comb begin
        if (col_last) begin
            col_next = '0;
            row_next = row_reg + FB'(1);
        end else begin
            col_next = col + CW'(1);
            row_next = row_reg;
        end
    end

    assign restart = cfg_we || (cmd.calc && emit && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= sobm_pkg::LW_RESET;
            frame_height_reg <= sobm_pkg::FH_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            if (cfg_we && cfg_index == sobm_pkg::REG_LINE_WIDTH) begin
                line_width_reg <= cfg_wdata[sobm_pkg::LW_BITS-1:0];
            end
            if (cfg_we && cfg_index == sobm_pkg::REG_FRAME_HEIGHT) begin
                frame_height_reg <= cfg_wdata[FB-1:0];
            end
            if (restart) begin
                col_reg <= '0;
                row_reg <= '0;
                for (int k = 0; k < 9; k++) begin
                    win_reg[k] <= '0;
                end
            end else if (cmd.calc) begin
                col_reg <= col_next;
                row_reg <= row_next;
                for (int k = 0; k < 9; k++) begin
                    win_reg[k] <= win_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            up_q_reg  <= upper_mem[col];
            mid_q_reg <= middle_mem[col];
            pix_reg   <= {s_red_in, s_green_in, s_blue_in};
            drain_reg <= s_drain;
        end
        if (cmd.calc) begin
            upper_mem[col]  <= mid;
            middle_mem[col] <= px;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            for (int ch = 0; ch < NC; ch++) begin
                sobm_pkg::chwin_t cw;
                for (int k = 0; k < 9; k++) begin
                    cw[k] = out_win[k][(NC-1-ch)*CB +: CB];
                end
                sq_reg[ch]   <= sobm_pkg::grad_sq(cw);
                root_reg[ch] <= '0;
            end
            bit_reg  <= sobm_pkg::BIT_IDX_W'(CB - 1);
            last_reg <= last;
        end else if (cmd.root_step) begin
            for (int ch = 0; ch < NC; ch++) begin
                logic [CB-1:0] t;
                t = root_reg[ch] | (CB'(1) << bit_reg);
                if ((SB'(t) * SB'(t)) <= sq_reg[ch]) begin
                    root_reg[ch] <= t;
                end
            end
            bit_reg <= bit_reg - sobm_pkg::BIT_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            for (int ch = 0; ch < NC; ch++) begin
                logic [2*CB-1:0] rr;
                rr = (2*CB)'(root_reg[ch] * root_reg[ch]) + (2*CB)'(root_reg[ch]);
                if (sq_reg[ch] > sobm_pkg::SAT_LIMIT) begin
                    edge_reg[ch] <= sobm_pkg::CH_MAX;
                end else if (sq_reg[ch] > SB'(rr)) begin
                    edge_reg[ch] <= root_reg[ch] + CB'(1);
                end else begin
                    edge_reg[ch] <= root_reg[ch];
                end
            end
            frame_end_reg <= last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red_edge   = edge_reg[0];
    assign m_green_edge = edge_reg[1];
    assign m_blue_edge  = edge_reg[2];
    assign m_frame_end  = frame_end_reg;

    assign status = '{
        emit:      emit,
        root_last: (bit_reg == '0),
        out_free:  (!m_valid_reg || m_ready),
        at_origin: ((col_reg == '0) && (row_reg == '0))
    };

endmodule
`default_nettype wire

// File: hdl/sobel_edge_magnitude_rgb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top
// Sobel gradient magnitude of a raster RGB stream, one result per channel.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel in raster order, one item per pixel. After
// the last pixel of a frame the source sends line_width + 1 items with
// s_drain high. Results leave on the m_ channel; the first line_width + 1
// items of a frame give none, after that every item gives one result, and
// m_frame_end marks the frame's last pixel.
// Each item first reads both line stores, then updates the window and forms
// the squared gradients. An item that gives a result then runs the
// bit-per-cycle square root, for the three channels in parallel, and loads
// the output register.
// The output register lets the next item enter while a result waits; a
// stalled receiver holds the sequencer in its output step until the result
// is taken. Reset clears the counters and window and loads 640 x 480.
// Writes on the cfg_ port restart the frame.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [sobm_pkg::IDX_BITS-1:0] cfg_index,
    input  wire logic [sobm_pkg::CFG_BITS-1:0] cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sobm_pkg::CH_BITS-1:0]  s_red_in,
    input  wire logic [sobm_pkg::CH_BITS-1:0]  s_green_in,
    input  wire logic [sobm_pkg::CH_BITS-1:0]  s_blue_in,
    input  wire logic                          s_drain,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sobm_pkg::CH_BITS-1:0]       m_red_edge,
    output logic [sobm_pkg::CH_BITS-1:0]       m_green_edge,
    output logic [sobm_pkg::CH_BITS-1:0]       m_blue_edge,
    output logic                               m_frame_end
);

    sobm_pkg::sobm_cmd_t    cmd;
    sobm_pkg::sobm_status_t status;

    sobm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sobm_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .s_drain      (s_drain),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_edge   (m_red_edge),
        .m_green_edge (m_green_edge),
        .m_blue_edge  (m_blue_edge),
        .m_frame_end  (m_frame_end),
        .cmd          (cmd),
        .status       (status)
    );

    // The input is closed in the cycle after an item is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // A configuration write restarts the raster position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> status.at_origin)
        else $error("configuration write did not restart the frame");

    // The output register is loaded only when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result overwritten before it was taken");

endmodule
`default_nettype wire
